// ===== sv/evsg_pkg.sv =====
// ----------------------------------------------------------------------------
// evsg_pkg
// Shared types and constants for the energy speech gate: register map,
// field widths, reset values, stop codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package evsg_pkg;

  // Field and register widths.
  localparam int unsigned FRAME_W   = 13;
  localparam int unsigned TRIG_W    = 13;
  localparam int unsigned SIL_W     = 16;
  localparam int unsigned MAXF_W    = 20;
  localparam int unsigned PROB_W    = 13;
  localparam int unsigned CAUSE_W   = 2;
  localparam int unsigned Q12_SHIFT = 12;

  // Configuration port.
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 4;

  // Register reset values.
  localparam logic [FRAME_W-1:0] FRAME_SAMPLES_RST = 13'd512;
  localparam logic [TRIG_W-1:0]  TRIGGER_LEVEL_RST = 13'd2048;
  localparam logic [SIL_W-1:0]   SILENCE_LIMIT_RST = 16'd60;
  localparam logic [MAXF_W-1:0]  MAX_FRAMES_RST    = 20'd600;

  // A probability of one in Q12.
  localparam logic [PROB_W-1:0] Q12_ONE = 13'd4096;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_FRAME_SAMPLES = 2'd0,
    REG_TRIGGER_LEVEL = 2'd1,
    REG_SILENCE_LIMIT = 2'd2,
    REG_MAX_FRAMES    = 2'd3
  } cfg_reg_e;

  // Reason reported with the frame that ends a capture.
  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_SILENCE = 2'd1,
    CAUSE_MAX_LEN = 2'd2
  } stop_cause_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MEAN,
    ST_ROOT,
    ST_SCALE,
    ST_EMIT
  } vad_state_e;

endpackage : evsg_pkg

`default_nettype wire

// ===== sv/energy_vad_speech_gate_core.sv =====
// ----------------------------------------------------------------------------
// energy_vad_speech_gate_core
// Energy based speech gate: sums the squares of the samples of a frame,
// takes the root of the mean, maps it to a Q12 probability and runs the
// capture session (start on first speech, stop on silence or length).
//
//   Channel  Handshake                  Payload
//   in       in_valid_i / in_ready_o    sample_i
//   out      out_valid_o / out_ready_i  speech_prob_o, frame_is_speech_o,
//                                       capture_start_o, capturing_o,
//                                       stop_cause_o
//   config   APB psel/penable/pready    paddr, pwdata, prdata
//
// A sample that ends no frame passes only through the squarer. A frame end then
// runs the divider for the mean, the square root, the divider again for scaling
// between the two levels (only when the root lies between them) and an emit
// step. One item is in work at a time. A held output item only stalls a frame
// end.
// Reset clears the frame sum, counters and session state; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module energy_vad_speech_gate_core
  import evsg_pkg::*;
#(
  parameter int unsigned MAX_FRAME_SAMPLES = 4096,
  parameter int unsigned SAMPLE_BITS       = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Sample input
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  // Frame result output
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [PROB_W-1:0]           speech_prob_o,
  output logic                        frame_is_speech_o,
  output logic                        capture_start_o,
  output logic                        capturing_o,
  output logic [CAUSE_W-1:0]          stop_cause_o,
  // Configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_AW-1:0]      paddr,
  input  wire logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]           prdata,
  output logic                        pready
);

  // Derived sizes and mapping levels.
  localparam int unsigned FRAME_MAX = (1 << FRAME_W) - 1;
  localparam int unsigned LIMIT_MAX =
    (MAX_FRAME_SAMPLES < FRAME_MAX) ? MAX_FRAME_SAMPLES : FRAME_MAX;
  localparam int unsigned SUM_W = 2*SAMPLE_BITS - 2 + $clog2(LIMIT_MAX + 1);
  localparam int unsigned SCALE_W = SAMPLE_BITS + Q12_SHIFT;
  localparam int unsigned NUM_W = (SUM_W > SCALE_W) ? SUM_W : SCALE_W;
  localparam int unsigned PROB_LOW  = ((1 << (SAMPLE_BITS-1)) + 5000) / 10000;
  localparam int unsigned PROB_HIGH = ((1 << (SAMPLE_BITS-1)) + 5) / 10;
  localparam int unsigned PROB_SPAN = PROB_HIGH - PROB_LOW;
  localparam int unsigned SPAN_W = $clog2(PROB_SPAN + 1);
  localparam int unsigned DEN_W = (SPAN_W > FRAME_W) ? SPAN_W : FRAME_W;
  localparam logic [FRAME_W-1:0] LIMIT_TOP = FRAME_W'(LIMIT_MAX);
  localparam logic [SAMPLE_BITS-1:0] LOW_LVL  = SAMPLE_BITS'(PROB_LOW);
  localparam logic [SAMPLE_BITS-1:0] HIGH_LVL = SAMPLE_BITS'(PROB_HIGH);

  vad_state_e state_q, state_d;

  logic [FRAME_W-1:0] frame_samples_q;
  logic [TRIG_W-1:0]  trigger_level_q;
  logic [SIL_W-1:0]   silence_limit_q;
  logic [MAXF_W-1:0]  max_frames_q;

  logic [FRAME_W-1:0] idx_q, idx_d, idx_inc;
  logic [FRAME_W-1:0] frame_limit;
  logic [PROB_W-1:0]  prob_q, prob_d;

  logic               seen_q, seen_d;
  logic               halted_q, halted_d;
  logic [MAXF_W-1:0]  since_start_q, since_start_d;
  logic [SIL_W-1:0]   since_speech_q, since_speech_d;
  logic               speech;
  logic               start_flag;
  logic               cap_flag;
  stop_cause_e        cause;

  logic               out_valid_q;
  logic [PROB_W-1:0]  out_prob_q;
  logic               out_speech_q;
  logic               out_start_q;
  logic               out_cap_q;
  stop_cause_e        out_cause_q;

  logic                     sq_start, sq_done, sum_clear;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [SUM_W-1:0]         sum;
  logic                     div_start, div_done;
  logic [NUM_W-1:0]         div_num, div_quo;
  logic [DEN_W-1:0]         div_den;
  logic                     rt_start, rt_done;
  logic [2*SAMPLE_BITS-1:0] rt_rad;
  logic [SAMPLE_BITS-1:0]   root;
  logic [SAMPLE_BITS-1:0]   rms_off;
  logic                     emit;
  logic                     wr_en;

  // Configuration port: zero wait states, write on the access phase.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_samples_q <= FRAME_SAMPLES_RST;
      trigger_level_q <= TRIGGER_LEVEL_RST;
      silence_limit_q <= SILENCE_LIMIT_RST;
      max_frames_q    <= MAX_FRAMES_RST;
    end else if (wr_en) begin
      unique case (cfg_reg_e'(paddr[3:2]))
        REG_FRAME_SAMPLES: frame_samples_q <= pwdata[FRAME_W-1:0];
        REG_TRIGGER_LEVEL: trigger_level_q <= pwdata[TRIG_W-1:0];
        REG_SILENCE_LIMIT: silence_limit_q <= pwdata[SIL_W-1:0];
        REG_MAX_FRAMES:    max_frames_q    <= pwdata[MAXF_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_reg_e'(paddr[3:2]))
      REG_FRAME_SAMPLES: prdata = APB_DW'(frame_samples_q);
      REG_TRIGGER_LEVEL: prdata = APB_DW'(trigger_level_q);
      REG_SILENCE_LIMIT: prdata = APB_DW'(silence_limit_q);
      REG_MAX_FRAMES:    prdata = APB_DW'(max_frames_q);
      default:           prdata = '0;
    endcase
  end

  // Effective frame length: zero acts as one, large values are clamped.
  always_comb begin
    if (frame_samples_q == '0) begin
      frame_limit = FRAME_W'(1);
    end else if (frame_samples_q > LIMIT_TOP) begin
      frame_limit = LIMIT_TOP;
    end else begin
      frame_limit = frame_samples_q;
    end
  end

  // Sample magnitude; the most negative code gives the top power of two.
  assign mag     = sample_i[SAMPLE_BITS-1] ? (~sample_i + SAMPLE_BITS'(1)) : sample_i;
  assign idx_inc = idx_q + FRAME_W'(1);
  assign rms_off = root - LOW_LVL;

  // A mean beyond the radicand range can follow a shortened frame. Its root
  // lies above the high level either way, so the radicand saturates.
  assign rt_rad = (|div_quo[NUM_W-1:2*SAMPLE_BITS]) ? '1 : div_quo[2*SAMPLE_BITS-1:0];

  evsg_sqacc #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_sqacc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .mag_i   (mag),
    .clear_i (sum_clear),
    .done_o  (sq_done),
    .sum_o   (sum)
  );

  evsg_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  evsg_sqrt #(
    .ROOT_W (SAMPLE_BITS)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rt_start),
    .rad_i   (rt_rad),
    .done_o  (rt_done),
    .root_o  (root)
  );

  // Controller: next state and unit strobes.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    prob_d    = prob_q;
    sq_start  = 1'b0;
    sum_clear = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    rt_start  = 1'b0;
    emit      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sq_start = 1'b1;
          state_d  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (sq_done) begin
          if (idx_inc >= frame_limit) begin
            idx_d     = '0;
            sum_clear = 1'b1;
            div_start = 1'b1;
            div_num   = NUM_W'(sum);
            div_den   = DEN_W'(frame_limit);
            state_d   = ST_MEAN;
          end else begin
            idx_d   = idx_inc;
            state_d = ST_IDLE;
          end
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          rt_start = 1'b1;
          state_d  = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rt_done) begin
          priority if (root < LOW_LVL) begin
            prob_d  = '0;
            state_d = ST_EMIT;
          end else if (root > HIGH_LVL) begin
            prob_d  = Q12_ONE;
            state_d = ST_EMIT;
          end else begin
            div_start = 1'b1;
            div_num   = NUM_W'({rms_off, Q12_SHIFT'(0)});
            div_den   = DEN_W'(PROB_SPAN);
            state_d   = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        if (div_done) begin
          prob_d  = div_quo[PROB_W-1:0];
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prob_q <= prob_d;
  end

  // Session decision for the frame that is being emitted.
  always_comb begin
    speech         = prob_q > trigger_level_q;
    seen_d         = seen_q;
    halted_d       = halted_q;
    since_start_d  = since_start_q;
    since_speech_d = since_speech_q;
    start_flag     = 1'b0;
    cap_flag       = 1'b0;
    cause          = CAUSE_NONE;
    if (!halted_q) begin
      if (since_start_q != '1) begin
        since_start_d = since_start_q + MAXF_W'(1);
      end
      if (speech) begin
        since_speech_d = '0;
        if (!seen_q) begin
          seen_d     = 1'b1;
          start_flag = 1'b1;
        end
      end else if (since_speech_q != '1) begin
        since_speech_d = since_speech_q + SIL_W'(1);
      end
      if (seen_d) begin
        cap_flag = 1'b1;
        priority if (since_speech_d > silence_limit_q) begin
          cause    = CAUSE_SILENCE;
          halted_d = 1'b1;
        end else if (since_start_d > max_frames_q) begin
          cause    = CAUSE_MAX_LEN;
          halted_d = 1'b1;
        end else begin
          cause = CAUSE_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q         <= 1'b0;
      halted_q       <= 1'b0;
      since_start_q  <= '0;
      since_speech_q <= '0;
    end else if (emit) begin
      seen_q         <= seen_d;
      halted_q       <= halted_d;
      since_start_q  <= since_start_d;
      since_speech_q <= since_speech_d;
    end
  end

  // Output register: holds one frame item until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_prob_q   <= prob_q;
      out_speech_q <= speech;
      out_start_q  <= start_flag;
      out_cap_q    <= cap_flag;
      out_cause_q  <= cause;
    end
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign speech_prob_o     = out_prob_q;
  assign frame_is_speech_o = out_speech_q;
  assign capture_start_o   = out_start_q;
  assign capturing_o       = out_cap_q;
  assign stop_cause_o      = out_cause_q;

endmodule : energy_vad_speech_gate_core

`default_nettype wire

// ===== sv/evsg_sqacc.sv =====
// ----------------------------------------------------------------------------
// evsg_sqacc
// Bit-serial squarer with frame accumulator. The magnitude is squared by
// shift-and-add, one multiplier bit per cycle, and the square is then added
// to the running frame sum.
// ----------------------------------------------------------------------------
`default_nettype none

module evsg_sqacc #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned SUM_W       = 43
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [SAMPLE_BITS-1:0] mag_i,
  input  wire logic                   clear_i,
  output logic                        done_o,
  output logic [SUM_W-1:0]            sum_o
);

  localparam int unsigned CNT_W = $clog2(SAMPLE_BITS + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLE_BITS);

  logic                   busy_q;
  logic                   done_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [SAMPLE_BITS-1:0] mcand_q;
  logic [2*SAMPLE_BITS:0] prod_q;
  logic [2*SAMPLE_BITS:0] prod_d;
  logic [SAMPLE_BITS:0]   upper;
  logic [SUM_W-1:0]       sum_q;

  // One shift-and-add step: add the multiplicand when the low bit is set.
  always_comb begin
    upper = prod_q[2*SAMPLE_BITS:SAMPLE_BITS];
    if (prod_q[0]) begin
      upper = prod_q[2*SAMPLE_BITS:SAMPLE_BITS] + (SAMPLE_BITS+1)'(mcand_q);
    end
    prod_d = {1'b0, upper, prod_q[SAMPLE_BITS-1:1]};
  end

  // Step control: SAMPLE_BITS multiply steps, then one accumulate step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Multiplier registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mag_i;
      prod_q  <= {(SAMPLE_BITS+1)'(0), mag_i};
    end else if (busy_q && cnt_q != LAST) begin
      prod_q <= prod_d;
    end
  end

  // Frame sum of squares.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (clear_i) begin
      sum_q <= '0;
    end else if (busy_q && cnt_q == LAST) begin
      sum_q <= sum_q + SUM_W'(prod_q[2*SAMPLE_BITS-1:0]);
    end
  end

  assign done_o = done_q;
  assign sum_o  = sum_q;

endmodule : evsg_sqacc

`default_nettype wire

// ===== sv/evsg_div.sv =====
// ----------------------------------------------------------------------------
// evsg_div
// Restoring divider, one quotient bit per cycle. Shared between the frame
// mean and the probability scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module evsg_div #(
  parameter int unsigned NUM_W = 43,
  parameter int unsigned DEN_W = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Shift in the next numerator bit and try to subtract the divisor.
  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    fits   = rem_sh >= {1'b0, den_q};
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the numerator register turns into the quotient bit by bit.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule : evsg_div

`default_nettype wire

// ===== sv/evsg_sqrt.sv =====
// ----------------------------------------------------------------------------
// evsg_sqrt
// Digit-by-digit integer square root, two radicand bits and one root bit per
// cycle. Gives the floor of the square root.
// ----------------------------------------------------------------------------
`default_nettype none

module evsg_sqrt #(
  parameter int unsigned ROOT_W = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [2*ROOT_W-1:0] rad_i,
  output logic                     done_o,
  output logic [ROOT_W-1:0]        root_o
);

  localparam int unsigned CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [2*ROOT_W-1:0] rad_q;
  logic [ROOT_W:0]     rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [ROOT_W+2:0]   rem_sh;
  logic [ROOT_W+2:0]   trial;
  logic [ROOT_W+2:0]   diff;
  logic                fits;

  // Bring down the next bit pair and test the trial value 4*root+1.
  always_comb begin
    rem_sh = {rem_q, rad_q[2*ROOT_W-1:2*ROOT_W-2]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = rem_sh - trial;
    fits   = rem_sh >= trial;
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*ROOT_W-3:0], 2'b00};
      rem_q  <= fits ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule : evsg_sqrt

`default_nettype wire

// ===== dv/energy_vad_speech_gate_core_test.sv =====
// ----------------------------------------------------------------------------
// energy_vad_speech_gate_core_test
// Self-checking bench for the energy speech gate. Samples are pushed through
// the valid/ready input with random gaps, and frame results are taken with
// random back-pressure. A scoreboard keeps its own frame energy sum, session
// counters and register copies, and checks every frame result field by
// field. The run moves from directed edge samples through a quiet period,
// a capture session and its stop, to traffic after the stop. This includes
// one loud frame cut short, so that its mean exceeds the sample range.
// ----------------------------------------------------------------------------

module energy_vad_speech_gate_core_test
  import evsg_pkg::*;
();

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned MAX_LEN       = 4096;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned RUN_LIMIT     = 40_000_000;
  // Level range of the rms to probability map (3 and 3277 for 16-bit audio).
  localparam longint unsigned PROB_LOW  =
    ((64'd1 << (SAMPLE_BITS - 1)) + 64'd5000) / 64'd10000;
  localparam longint unsigned PROB_HIGH =
    ((64'd1 << (SAMPLE_BITS - 1)) + 64'd5) / 64'd10;

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic              speech;
    logic              start;
    logic              capturing;
    stop_cause_e       cause;
  } frame_res_t;

  // Frame scoreboard: predicts the result of each frame end and checks it.
  class gate_scoreboard;
    frame_res_t        due_q[$];
    logic [FRAME_W-1:0] len_reg;
    logic [TRIG_W-1:0]  trig_reg;
    logic [SIL_W-1:0]   quiet_reg;
    logic [MAXF_W-1:0]  length_reg;
    longint unsigned    energy_sum;
    int unsigned        fill;
    bit                 session_open;
    bit                 stopped;
    logic [MAXF_W-1:0]  frames_total;
    logic [SIL_W-1:0]   frames_quiet;
    int unsigned        errors;
    int unsigned        frames_checked;
    int unsigned        speech_frames;
    int unsigned        starts;
    int unsigned        silence_stops;
    int unsigned        length_stops;

    function new();
      len_reg      = FRAME_SAMPLES_RST;
      trig_reg     = TRIGGER_LEVEL_RST;
      quiet_reg    = SILENCE_LIMIT_RST;
      length_reg   = MAX_FRAMES_RST;
      energy_sum   = 0;
      fill         = 0;
      session_open = 1'b0;
      stopped      = 1'b0;
      frames_total = '0;
      frames_quiet = '0;
      errors       = 0;
      frames_checked = 0;
      speech_frames  = 0;
      starts         = 0;
      silence_stops  = 0;
      length_stops   = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void set_reg(cfg_reg_e r, logic [31:0] v);
      case (r)
        REG_FRAME_SAMPLES: len_reg    = v[FRAME_W-1:0];
        REG_TRIGGER_LEVEL: trig_reg   = v[TRIG_W-1:0];
        REG_SILENCE_LIMIT: quiet_reg  = v[SIL_W-1:0];
        REG_MAX_FRAMES:    length_reg = v[MAXF_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(cfg_reg_e r);
      case (r)
        REG_FRAME_SAMPLES: return 32'(len_reg);
        REG_TRIGGER_LEVEL: return 32'(trig_reg);
        REG_SILENCE_LIMIT: return 32'(quiet_reg);
        default:           return 32'(length_reg);
      endcase
    endfunction

    // Frame length in force: zero acts as one, the maximum caps the rest.
    function int unsigned frame_length();
      if (len_reg == 0) return 1;
      if (len_reg > MAX_LEN) return MAX_LEN;
      return 32'(len_reg);
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function longint unsigned root_floor(longint unsigned x);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd1 << 22;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid <= x) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    // Accepted sample: add its square and, at a frame end, queue the result.
    function void note_sample(logic [SAMPLE_BITS-1:0] s);
      longint unsigned mag, rms;
      int unsigned     lim;
      frame_res_t      r;
      mag = 64'(s);
      if (s[SAMPLE_BITS-1]) mag = (64'd1 << SAMPLE_BITS) - mag;
      energy_sum += mag * mag;
      fill++;
      lim = frame_length();
      if (fill < lim) return;

      rms = root_floor(energy_sum / lim);
      if (rms < PROB_LOW) r.prob = '0;
      else if (rms > PROB_HIGH) r.prob = Q12_ONE;
      else r.prob = PROB_W'(((rms - PROB_LOW) << Q12_SHIFT) / (PROB_HIGH - PROB_LOW));
      r.speech    = (r.prob > trig_reg);
      r.start     = 1'b0;
      r.capturing = 1'b0;
      r.cause     = CAUSE_NONE;
      energy_sum  = 0;
      fill        = 0;

      // Session bookkeeping stays frozen once capture has stopped.
      if (!stopped) begin
        if (frames_total != '1) frames_total++;
        if (r.speech) begin
          frames_quiet = '0;
          if (!session_open) begin
            session_open = 1'b1;
            r.start      = 1'b1;
          end
        end else if (frames_quiet != '1) begin
          frames_quiet++;
        end
        if (session_open) begin
          r.capturing = 1'b1;
          if (frames_quiet > quiet_reg) begin
            r.cause = CAUSE_SILENCE;
            stopped = 1'b1;
          end else if (frames_total > length_reg) begin
            r.cause = CAUSE_MAX_LEN;
            stopped = 1'b1;
          end
        end
      end
      due_q = {due_q, r};
    endfunction

    // Accepted frame result: compare with the oldest prediction.
    task check_frame(frame_res_t got);
      frame_res_t want;
      if (due_q.size() == 0) begin
        report($sformatf("frame result with nothing outstanding (prob %0d)", got.prob));
        return;
      end
      want = due_q.pop_front();
      frames_checked++;
      if (got.prob !== want.prob)
        report($sformatf("frame %0d speech_prob %0d, expected %0d",
                         frames_checked, got.prob, want.prob));
      if (got.speech !== want.speech)
        report($sformatf("frame %0d frame_is_speech %b, expected %b",
                         frames_checked, got.speech, want.speech));
      if (got.start !== want.start)
        report($sformatf("frame %0d capture_start %b, expected %b",
                         frames_checked, got.start, want.start));
      if (got.capturing !== want.capturing)
        report($sformatf("frame %0d capturing %b, expected %b",
                         frames_checked, got.capturing, want.capturing));
      if (got.cause !== want.cause)
        report($sformatf("frame %0d stop_cause %0d, expected %0d",
                         frames_checked, got.cause, want.cause));
      if (want.speech) speech_frames++;
      if (want.start) starts++;
      if (want.cause == CAUSE_SILENCE) silence_stops++;
      if (want.cause == CAUSE_MAX_LEN) length_stops++;
    endtask
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [SAMPLE_BITS-1:0] sample_i    = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [PROB_W-1:0]      speech_prob_o;
  logic                   frame_is_speech_o;
  logic                   capture_start_o;
  logic                   capturing_o;
  logic [CAUSE_W-1:0]     stop_cause_o;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [APB_AW-1:0]      paddr       = '0;
  logic [APB_DW-1:0]      pwdata      = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  gate_scoreboard sb;
  int unsigned    samples_sent = 0;
  int unsigned    reg_writes   = 0;
  int unsigned    tx_calm      = 0;
  int unsigned    rx_calm      = 0;
  int unsigned    rx_stall     = 0;

  energy_vad_speech_gate_core #(
    .MAX_FRAME_SAMPLES(MAX_LEN),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .speech_prob_o    (speech_prob_o),
    .frame_is_speech_o(frame_is_speech_o),
    .capture_start_o  (capture_start_o),
    .capturing_o      (capturing_o),
    .stop_cause_o     (stop_cause_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Clock with a period of four time units.
  always #2 clk_i = ~clk_i;

  // Result side back-pressure: calm stretches, short stalls and a few long ones.
  initial begin
    int unsigned r;
    forever begin
      @(negedge clk_i);
      if (rx_stall != 0) begin
        out_ready_i = 1'b0;
        rx_stall--;
      end else begin
        out_ready_i = 1'b1;
        if (rx_calm != 0) begin
          rx_calm--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 5) rx_calm = $urandom_range(50, 400);
          else if (r < 25) rx_stall = $urandom_range(1, 4);
          else if (r < 28) rx_stall = $urandom_range(20, 200);
        end
      end
    end
  end

  // Every accepted frame result goes to the scoreboard.
  always @(posedge clk_i) begin
    frame_res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.prob      = speech_prob_o;
      got.speech    = frame_is_speech_o;
      got.start     = capture_start_o;
      got.capturing = capturing_o;
      got.cause     = stop_cause_e'(stop_cause_o);
      sb.check_frame(got);
    end
  end

  // Offer one sample after a random gap and wait until it is taken.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int unsigned gap, r;
    gap = 0;
    if (tx_calm != 0) begin
      tx_calm--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) tx_calm = $urandom_range(20, 200);
      else if (r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 15);
      else gap = $urandom_range(30, 150);
    end
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i   = s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
    samples_sent++;
  endtask

  // Hold the input back until every predicted frame result has come back,
  // then give the block time to finish any sample still in work.
  task automatic wait_drained(input int unsigned settle);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Register write followed by a read back of the same register.
  task automatic cfg_write(input cfg_reg_e r, input logic [31:0] v);
    logic [31:0] got;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(r, v);
    reg_writes++;
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== sb.reg_value(r))
      sb.report($sformatf("register %s reads %0h, expected %0h",
                          r.name(), got, sb.reg_value(r)));
  endtask

  // New frame length while idle: mostly short frames, sometimes zero.
  task automatic reconfig_frame();
    int unsigned r;
    logic [31:0] v;
    wait_drained(SETTLE_CYCLES);
    r = $urandom_range(0, 99);
    if (r < 8) v = 0;
    else if (r < 75) v = $urandom_range(1, 8);
    else if (r < 95) v = $urandom_range(9, 48);
    else v = $urandom_range(49, 128);
    cfg_write(REG_FRAME_SAMPLES, v);
  endtask

  // Fill the rest of the current frame with loud, quiet or full-range audio.
  task automatic send_frame(input int unsigned loud_pct);
    int unsigned len, n, r, amp;
    int          sv;
    logic [SAMPLE_BITS-1:0] s;
    len = sb.frame_length();
    n   = (sb.fill < len) ? len - sb.fill : 1;
    r   = $urandom_range(0, 99);
    amp = (r < loud_pct) ? $urandom_range(800, 32767) : $urandom_range(0, 400);
    repeat (n) begin
      if (r >= 85) begin
        s = SAMPLE_BITS'($urandom());
      end else begin
        sv = int'($urandom_range(0, 2 * amp)) - int'(amp);
        s  = sv[SAMPLE_BITS-1:0];
      end
      send_sample(s);
    end
  endtask

  // Whole frames until the sample budget is used, sometimes letting all
  // outstanding results drain first.
  task automatic run_frames(input int unsigned budget, input int unsigned loud_pct);
    int unsigned first;
    first = samples_sent;
    while (samples_sent - first < budget) begin
      if ($urandom_range(0, 29) == 0) wait_drained(0);
      send_frame(loud_pct);
    end
  endtask

  // Main sequence.
  initial begin
    logic [SAMPLE_BITS-1:0] edge_samples[13];
    edge_samples = '{16'h0000, 16'h0001, 16'hFFFF, 16'h0002, 16'd3, 16'd4,
                     16'd3276, 16'd3277, 16'd3278, 16'h7FFF, 16'h8000,
                     16'h5555, 16'hAAAA};
    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // One-sample frames across the level map, with speech held off.
    cfg_write(REG_FRAME_SAMPLES, 1);
    cfg_write(REG_TRIGGER_LEVEL, 8191);
    cfg_write(REG_SILENCE_LIMIT, 65535);
    cfg_write(REG_MAX_FRAMES, 32'hFFFFF);
    foreach (edge_samples[i]) send_sample(edge_samples[i]);

    // A frame length of zero behaves as one.
    wait_drained(SETTLE_CYCLES);
    cfg_write(REG_FRAME_SAMPLES, 0);
    send_sample(16'd3);
    send_sample(16'h8001);
    send_sample(16'd0);

    // Shrinking the frame below the samples already taken ends it at once.
    wait_drained(SETTLE_CYCLES);
    cfg_write(REG_FRAME_SAMPLES, 8);
    repeat (5) send_sample(16'd2000);
    wait_drained(SETTLE_CYCLES);
    cfg_write(REG_FRAME_SAMPLES, 3);
    send_sample(16'hF000);

    // Quiet period: no frame can beat a trigger level of one.
    wait_drained(SETTLE_CYCLES);
    cfg_write(REG_TRIGGER_LEVEL, 4096);
    repeat (2) begin
      reconfig_frame();
      run_frames(100, 50);
    end

    // Capture session: the first phase lets any non-zero level start it.
    wait_drained(SETTLE_CYCLES);
    cfg_write(REG_SILENCE_LIMIT, 30);
    cfg_write(REG_TRIGGER_LEVEL, 0);
    run_frames(150, 50);
    repeat (4) begin
      reconfig_frame();
      cfg_write(REG_TRIGGER_LEVEL, $urandom_range(0, 3500));
      cfg_write(REG_SILENCE_LIMIT, $urandom_range(12, 40));
      run_frames(150, 50);
    end

    // Both limits at zero: the next frame stops capture, silence first.
    wait_drained(SETTLE_CYCLES);
    cfg_write(REG_SILENCE_LIMIT, 0);
    cfg_write(REG_MAX_FRAMES, 0);
    run_frames(150, 50);

    // After the stop: a frame at the largest square, cut down to one sample
    // so that its mean lies far beyond the sample range.
    wait_drained(SETTLE_CYCLES);
    cfg_write(REG_FRAME_SAMPLES, 64);
    repeat (63) send_sample(16'h8000);
    wait_drained(SETTLE_CYCLES);
    cfg_write(REG_FRAME_SAMPLES, 1);
    send_sample(16'h8000);
    wait_drained(SETTLE_CYCLES);
    cfg_write(REG_FRAME_SAMPLES, 4096);
    cfg_write(REG_SILENCE_LIMIT, 65535);
    cfg_write(REG_MAX_FRAMES, 32'hFFFFF);
    repeat (2) begin
      reconfig_frame();
      cfg_write(REG_TRIGGER_LEVEL, $urandom_range(0, 4096));
      run_frames(100, 50);
    end

    wait_drained(SETTLE_CYCLES);
    $display("Run covered %0d samples and %0d frame results (%0d speech)",
             samples_sent, sb.frames_checked, sb.speech_frames);
    $display("over %0d register writes; capture starts %0d, silence stops %0d, length stops %0d.",
             reg_writes, sb.starts, sb.silence_stops, sb.length_stops);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule
